FILE: rtl/core/moe_rtr_pkg.sv
`default_nettype none
package moe_rtr_pkg;

  localparam int SCORE_W   = 16;
  localparam int E_W       = 17;
  localparam int SUM_W     = 20;
  localparam int Q_W       = 17;
  localparam int SC_W      = 7;
  localparam int CNT_W     = 13;
  localparam int HID_W     = 16;
  localparam int EPS_W     = 15;
  localparam int NE_W      = 7;
  localparam int K_W       = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int EID_W     = 6;
  localparam int W_W       = 16;
  localparam int TOK_W     = 12;
  localparam int SLOT_W    = 12;
  localparam int OFF_W     = 28;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_EXPERTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_DIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_EPS  = 3'd5;

  localparam logic [31:0]      LCG_MUL   = 32'd1664525;
  localparam logic [31:0]      LCG_INC   = 32'd1013904223;
  localparam logic [31:0]      SEED_INIT = 32'd42;
  localparam logic [15:0]      NOISE_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_SAT   = 13'h1FFF;
  localparam logic [63:0]      EXP_STEP  = 64'd4034748382;

  typedef struct packed {
    logic ins;
    logic shl;
    logic eload;
  } cell_ctrl_t;

  typedef struct packed {
    logic below_k;
    logic below_f;
    logic at_f;
    logic below_r;
  } cell_pos_t;

  // exp(-idx/16) in Q1.16, built by repeated Q32 scaling; elaboration only
  function automatic logic [E_W-1:0] exp_entry(input int idx);
    logic [63:0] v;
    v = 64'h1_0000_0000;
    for (int i = 0; i < idx; i++) begin
      v = (v * EXP_STEP + 64'h8000_0000) >> 32;
    end
    return E_W'((v + 64'h8000) >> 16);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/moe_rtr_cell.sv
`default_nettype none
module moe_rtr_cell #(
  parameter int IDW = 6,
  parameter int TBL = 256
) (
  input  wire                                 clk,
  input  moe_rtr_pkg::cell_ctrl_t             ctrl,
  input  moe_rtr_pkg::cell_pos_t              pos,
  input  wire signed [moe_rtr_pkg::SCORE_W-1:0] s_new,
  input  wire        [IDW-1:0]                id_new,
  input  wire signed [moe_rtr_pkg::SCORE_W-1:0] top_score,
  input  wire signed [moe_rtr_pkg::SCORE_W-1:0] prev_score,
  input  wire        [IDW-1:0]                prev_id,
  input  wire                                 prev_gt,
  input  wire signed [moe_rtr_pkg::SCORE_W-1:0] next_score,
  input  wire        [IDW-1:0]                next_id,
  input  wire        [moe_rtr_pkg::E_W-1:0]   next_e,
  output logic signed [moe_rtr_pkg::SCORE_W-1:0] score,
  output logic       [IDW-1:0]                id,
  output logic       [moe_rtr_pkg::E_W-1:0]   e,
  output logic                                gt
);

  localparam int IXW = $clog2(TBL);

  logic signed [moe_rtr_pkg::SCORE_W-1:0] score_r;
  logic        [IDW-1:0]                  id_r;
  logic        [moe_rtr_pkg::E_W-1:0]     e_r;
  logic        [moe_rtr_pkg::E_W-1:0]     lut [TBL];
  logic signed [moe_rtr_pkg::SCORE_W:0]   diff;
  logic        [11:0]                     idx;
  logic        [moe_rtr_pkg::E_W-1:0]     e_lut;
  logic                                   take_prev;
  logic                                   take_new;

  for (genvar g = 0; g < TBL; g++) begin : g_lut
    assign lut[g] = moe_rtr_pkg::exp_entry(g);
  end

  always_comb begin
    diff  = 17'(top_score) - 17'(score_r);
    idx   = diff[16] ? 12'd0 : diff[15:4];
    e_lut = (13'(idx) < 13'(TBL)) ? lut[idx[IXW-1:0]] : '0;
  end

  assign gt        = pos.below_f && (s_new > score_r);
  assign take_prev = pos.below_k && prev_gt;
  assign take_new  = pos.below_k && !take_prev && (gt || pos.at_f);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (take_prev) begin
        score_r <= prev_score;
        id_r    <= prev_id;
      end else if (take_new) begin
        score_r <= s_new;
        id_r    <= id_new;
      end
    end
    if (ctrl.shl) begin
      score_r <= next_score;
      id_r    <= next_id;
      e_r     <= next_e;
    end
    if (ctrl.eload) begin
      e_r <= pos.below_r ? e_lut : '0;
    end
  end

  assign score = score_r;
  assign id    = id_r;
  assign e     = e_r;

endmodule
`default_nettype wire

FILE: rtl/core/moe_rtr_div.sv
`default_nettype none
module moe_rtr_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire [moe_rtr_pkg::E_W-1:0]      e,
  input  wire [moe_rtr_pkg::SUM_W-1:0]    sum,
  output logic                            done,
  output logic [moe_rtr_pkg::Q_W-1:0]     quot
);

  localparam int REM_W = moe_rtr_pkg::SUM_W + 1;
  localparam int NUM_W = moe_rtr_pkg::E_W + 16 + 1;
  localparam int CW    = $clog2(moe_rtr_pkg::Q_W);

  logic [REM_W-1:0]              rem_r;
  logic [moe_rtr_pkg::Q_W-1:0]   lo_r;
  logic [moe_rtr_pkg::Q_W-1:0]   q_r;
  logic [CW-1:0]                 cnt_r;
  logic                          run_r;
  logic                          done_r;
  logic [NUM_W-1:0]              num;
  logic [REM_W:0]                trial;
  logic                          ge;

  // rounded numerator e*2^16 + sum/2; quotient stays below 2^17
  assign num   = (NUM_W'(e) << 16) + NUM_W'(sum >> 1);
  assign trial = {rem_r, lo_r[moe_rtr_pkg::Q_W-1]};
  assign ge    = trial >= (REM_W+1)'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(moe_rtr_pkg::Q_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num >> moe_rtr_pkg::Q_W);
      lo_r  <= num[moe_rtr_pkg::Q_W-1:0];
    end else if (run_r) begin
      rem_r <= ge ? REM_W'(trial - (REM_W+1)'(sum)) : REM_W'(trial);
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[moe_rtr_pkg::Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

FILE: rtl/core/moe_topk_router_with_capacity.sv
`default_nettype none
// Channel   Direction  Handshake           Beat
// cfg       in         cfg_we              one register write (index, data)
// in        in         in_valid/in_stall   one router score of the next expert
// out       out        out_valid/out_stall one selected expert of a token
//
// With jitter on, a score passes an LCG step, a noise multiply and rounding
// before its insert. A token's last score is followed by the exponent load and
// sum; each result then takes the count memory read, the bit-serial weight
// divider (17 steps) and the output load. Reset is synchronous and clears
// control state and counts. The output register holds a beat through
// out_stall; the next score is taken while the token's last beat still waits.
module moe_topk_router_with_capacity #(
  parameter int MAX_EXPERTS     = 64,
  parameter int MAX_TOP_K       = 8,
  parameter int MAX_TOKENS      = 4096,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     cfg_we,
  input  wire [moe_rtr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [moe_rtr_pkg::CFG_W-1:0]            cfg_wdata,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire signed [moe_rtr_pkg::SCORE_W-1:0]   in_score,
  input  wire                                     in_batch_start,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic [moe_rtr_pkg::EID_W-1:0]           out_expert_id,
  output logic [moe_rtr_pkg::W_W-1:0]             out_weight,
  output logic [moe_rtr_pkg::TOK_W-1:0]           out_token_index,
  output logic                                    out_kept,
  output logic [moe_rtr_pkg::SLOT_W-1:0]          out_slot,
  output logic [moe_rtr_pkg::OFF_W-1:0]           out_input_offset,
  output logic [moe_rtr_pkg::OFF_W-1:0]           out_output_offset,
  output logic                                    out_last
);

  localparam int IDW = $clog2(MAX_EXPERTS);
  localparam int TKW = $clog2(MAX_TOKENS);
  localparam int TBL = (EXP_TABLE_DEPTH > 256) ? 256 : EXP_TABLE_DEPTH;
  localparam int SW  = moe_rtr_pkg::SCORE_W;
  localparam int KW  = moe_rtr_pkg::K_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_J1   = 4'd1;
  localparam logic [3:0] ST_J2   = 4'd2;
  localparam logic [3:0] ST_J3   = 4'd3;
  localparam logic [3:0] ST_INS  = 4'd4;
  localparam logic [3:0] ST_EXP  = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_CNT  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_LOAD = 4'd10;

  // configuration
  logic [moe_rtr_pkg::NE_W-1:0]  ne_r;
  logic [KW-1:0]                 topk_r;
  logic [moe_rtr_pkg::CNT_W-1:0] cap_r;
  logic [moe_rtr_pkg::HID_W-1:0] hid_r;
  logic                          jen_r;
  logic [moe_rtr_pkg::EPS_W-1:0] eps_r;

  // control
  logic [3:0]                    state_r;
  logic [moe_rtr_pkg::SC_W-1:0]  sc_r;
  logic [KW-1:0]                 fill_r;
  logic [KW-1:0]                 res_r;
  logic [KW-1:0]                 ridx_r;
  logic [TKW-1:0]                tok_r;
  logic [TKW-1:0]                tok_emit_r;
  logic [31:0]                   seed_r;
  logic [MAX_EXPERTS-1:0]        cvld_r;

  // datapath
  logic signed [SW-1:0]          s_r;
  logic [30:0]                   mag_r;
  logic                          neg_r;
  logic [moe_rtr_pkg::SUM_W-1:0] sum_r;
  logic [moe_rtr_pkg::CNT_W-1:0] cmem [MAX_EXPERTS];
  logic [moe_rtr_pkg::CNT_W-1:0] crd_r;
  logic                          crd_vld_r;
  logic                          kept_r;
  logic [moe_rtr_pkg::CNT_W-1:0] slot_r;
  logic [31:0]                   ioff_r;
  logic [28:0]                   ooff_r;

  // output register
  logic                          ov_r;
  logic [moe_rtr_pkg::EID_W-1:0] o_eid_r;
  logic [moe_rtr_pkg::W_W-1:0]   o_w_r;
  logic [moe_rtr_pkg::TOK_W-1:0] o_tok_r;
  logic                          o_kept_r;
  logic [moe_rtr_pkg::SLOT_W-1:0] o_slot_r;
  logic [moe_rtr_pkg::OFF_W-1:0] o_ioff_r;
  logic [moe_rtr_pkg::OFF_W-1:0] o_ooff_r;
  logic                          o_last_r;

  // cell chain
  moe_rtr_pkg::cell_ctrl_t       cctrl;
  moe_rtr_pkg::cell_pos_t        cpos   [MAX_TOP_K];
  logic signed [SW-1:0]          c_score[MAX_TOP_K];
  logic [IDW-1:0]                c_id   [MAX_TOP_K];
  logic [moe_rtr_pkg::E_W-1:0]   c_e    [MAX_TOP_K];
  logic                          c_gt   [MAX_TOP_K];

  logic [8:0]                    n_eff;
  logic [KW-1:0]                 k_cl;
  logic [KW-1:0]                 k_eff;
  logic [KW-1:0]                 f_eff;
  logic [KW-1:0]                 fill_inc;
  logic                          in_acc;
  logic [moe_rtr_pkg::SC_W-1:0]  sc_cur;
  logic                          jit_on;
  logic                          tok_end;
  logic                          load;
  logic                          res_last;
  logic                          div_start;
  logic                          div_done;
  logic [moe_rtr_pkg::Q_W-1:0]   div_q;
  logic [moe_rtr_pkg::SUM_W-1:0] sum_c;
  logic [15:0]                   nz_r;
  logic [16:0]                   nz_t;
  logic [15:0]                   nz_a;
  logic [31:0]                   jx;
  logic [15:0]                   jq0;
  logic [16:0]                   jrr;
  logic [16:0]                   jq;
  logic signed [17:0]            js;
  logic [moe_rtr_pkg::CNT_W-1:0] ccur;
  logic                          ckeep;
  logic [7:0]                    head_id8;
  logic [15:0]                   tok16;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r   <= 7'd8;
      topk_r <= 4'd2;
      cap_r  <= 13'd4096;
      hid_r  <= 16'd1;
      jen_r  <= 1'b0;
      eps_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        moe_rtr_pkg::REG_NUM_EXPERTS: ne_r   <= cfg_wdata[moe_rtr_pkg::NE_W-1:0];
        moe_rtr_pkg::REG_TOP_K:       topk_r <= cfg_wdata[KW-1:0];
        moe_rtr_pkg::REG_CAPACITY:    cap_r  <= cfg_wdata[moe_rtr_pkg::CNT_W-1:0];
        moe_rtr_pkg::REG_HIDDEN_DIM:  hid_r  <= cfg_wdata[moe_rtr_pkg::HID_W-1:0];
        moe_rtr_pkg::REG_JITTER_EN:   jen_r  <= cfg_wdata[0];
        moe_rtr_pkg::REG_JITTER_EPS:  eps_r  <= cfg_wdata[moe_rtr_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ne_r == '0) begin
      n_eff = 9'd1;
    end else if (9'(ne_r) > 9'(MAX_EXPERTS)) begin
      n_eff = 9'(MAX_EXPERTS);
    end else begin
      n_eff = 9'(ne_r);
    end
    if (topk_r == '0) begin
      k_cl = 4'd1;
    end else if (topk_r > KW'(MAX_TOP_K)) begin
      k_cl = KW'(MAX_TOP_K);
    end else begin
      k_cl = topk_r;
    end
    k_eff    = (9'(k_cl) > n_eff) ? KW'(n_eff) : k_cl;
    f_eff    = (fill_r < k_eff) ? fill_r : k_eff;
    fill_inc = (fill_r < KW'(MAX_TOP_K)) ? fill_r + 1'b1 : fill_r;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sc_cur   = in_batch_start ? '0 : sc_r;
  assign jit_on   = jen_r && (eps_r != '0);
  assign tok_end  = (9'(sc_r) + 9'd1) >= n_eff;
  assign load     = (state_r == ST_LOAD) && (!ov_r || !out_stall);
  assign res_last = (ridx_r + 1'b1) == res_r;
  assign div_start = (state_r == ST_RD);

  // noise: round(|2r-65535|*eps / 65535), divide by 2^16-1 via fold and one correction
  always_comb begin
    nz_r = seed_r[15:0];
    nz_t = {nz_r, 1'b0} - 17'(moe_rtr_pkg::NOISE_MAX);
    nz_a = nz_r[15] ? nz_t[15:0] : 16'(17'(moe_rtr_pkg::NOISE_MAX) - {nz_r, 1'b0});
    jx   = 32'(mag_r) + 32'd32767;
    jq0  = jx[31:16];
    jrr  = 17'(jx[15:0]) + 17'(jq0);
    jq   = 17'(jq0) + ((jrr >= 17'(moe_rtr_pkg::NOISE_MAX)) ? 17'd1 : 17'd0);
    js   = 18'(s_r) + (neg_r ? -18'(jq) : 18'(jq));
  end

  always_comb begin
    cctrl.ins   = (state_r == ST_INS);
    cctrl.shl   = load && !res_last;
    cctrl.eload = (state_r == ST_EXP);
  end

  for (genvar g = 0; g < MAX_TOP_K; g++) begin : g_cell
    logic signed [SW-1:0]        p_score;
    logic [IDW-1:0]              p_id;
    logic                        p_gt;
    logic signed [SW-1:0]        n_score;
    logic [IDW-1:0]              n_id;
    logic [moe_rtr_pkg::E_W-1:0] n_e;

    if (g == 0) begin : g_head
      assign p_score = '0;
      assign p_id    = '0;
      assign p_gt    = 1'b0;
    end else begin : g_body
      assign p_score = c_score[g-1];
      assign p_id    = c_id[g-1];
      assign p_gt    = c_gt[g-1];
    end
    if (g == MAX_TOP_K - 1) begin : g_tail
      assign n_score = '0;
      assign n_id    = '0;
      assign n_e     = '0;
    end else begin : g_mid
      assign n_score = c_score[g+1];
      assign n_id    = c_id[g+1];
      assign n_e     = c_e[g+1];
    end

    assign cpos[g].below_k = KW'(g) < k_eff;
    assign cpos[g].below_f = KW'(g) < f_eff;
    assign cpos[g].at_f    = KW'(g) == f_eff;
    assign cpos[g].below_r = KW'(g) < res_r;

    moe_rtr_cell #(
      .IDW (IDW),
      .TBL (TBL)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cctrl),
      .pos        (cpos[g]),
      .s_new      (s_r),
      .id_new     (IDW'(sc_r)),
      .top_score  (c_score[0]),
      .prev_score (p_score),
      .prev_id    (p_id),
      .prev_gt    (p_gt),
      .next_score (n_score),
      .next_id    (n_id),
      .next_e     (n_e),
      .score      (c_score[g]),
      .id         (c_id[g]),
      .e          (c_e[g]),
      .gt         (c_gt[g])
    );
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < MAX_TOP_K; i++) begin
      sum_c = sum_c + moe_rtr_pkg::SUM_W'(c_e[i]);
    end
  end

  moe_rtr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .e     (c_e[0]),
    .sum   (sum_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign ccur  = crd_vld_r ? crd_r : '0;
  assign ckeep = ccur < cap_r;

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sc_r    <= '0;
      fill_r  <= '0;
      res_r   <= '0;
      ridx_r  <= '0;
      tok_r   <= '0;
      seed_r  <= moe_rtr_pkg::SEED_INIT;
      cvld_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sc_r <= sc_cur;
            if (sc_cur == '0) begin
              fill_r <= '0;
            end
            if (in_batch_start) begin
              tok_r  <= '0;
              cvld_r <= '0;
            end
            state_r <= jit_on ? ST_J1 : ST_INS;
          end
        end
        ST_J1: begin
          seed_r  <= seed_r * moe_rtr_pkg::LCG_MUL + moe_rtr_pkg::LCG_INC;
          state_r <= ST_J2;
        end
        ST_J2: state_r <= ST_J3;
        ST_J3: state_r <= ST_INS;
        ST_INS: begin
          if (tok_end) begin
            res_r  <= (fill_inc < k_eff) ? fill_inc : k_eff;
            sc_r   <= '0;
            fill_r <= '0;
            tok_r  <= (tok_r == TKW'(MAX_TOKENS - 1)) ? '0 : tok_r + 1'b1;
            state_r <= ST_EXP;
          end else begin
            sc_r    <= sc_r + 1'b1;
            fill_r  <= fill_inc;
            state_r <= ST_IDLE;
          end
        end
        ST_EXP: state_r <= ST_SUM;
        ST_SUM: begin
          ridx_r  <= '0;
          state_r <= ST_RD;
        end
        ST_RD:  state_r <= ST_CNT;
        ST_CNT: begin
          if (ckeep) begin
            cvld_r[c_id[0]] <= 1'b1;
          end
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (load) begin
            if (res_last) begin
              state_r <= ST_IDLE;
            end else begin
              ridx_r  <= ridx_r + 1'b1;
              state_r <= ST_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r <= in_score;
    end
    if (state_r == ST_IDLE && in_acc) begin
      tok_emit_r <= in_batch_start ? '0 : tok_r;
    end
    if (state_r == ST_J2) begin
      mag_r <= 31'(nz_a) * 31'(eps_r);
      neg_r <= ~nz_r[15];
    end
    if (state_r == ST_J3) begin
      if (js > 18'sd32767) begin
        s_r <= 16'sh7FFF;
      end else if (js < -18'sd32768) begin
        s_r <= 16'sh8000;
      end else begin
        s_r <= js[SW-1:0];
      end
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_c;
    end
    if (state_r == ST_RD) begin
      crd_r     <= cmem[c_id[0]];
      crd_vld_r <= cvld_r[c_id[0]];
    end
    if (state_r == ST_CNT) begin
      kept_r <= ckeep;
      slot_r <= ckeep ? ccur : '0;
      if (ckeep) begin
        cmem[c_id[0]] <= ccur + 1'b1;
      end
    end
    ioff_r <= 32'(tok_emit_r) * 32'(hid_r);
    ooff_r <= 29'(slot_r * 29'(hid_r));
  end

  assign head_id8 = 8'(c_id[0]);
  assign tok16    = 16'(tok_emit_r);

  always_ff @(posedge clk) begin
    if (load) begin
      o_eid_r  <= head_id8[moe_rtr_pkg::EID_W-1:0];
      o_w_r    <= div_q[moe_rtr_pkg::Q_W-1] ? 16'hFFFF : div_q[moe_rtr_pkg::W_W-1:0];
      o_tok_r  <= tok16[moe_rtr_pkg::TOK_W-1:0];
      o_kept_r <= kept_r;
      o_slot_r <= slot_r[moe_rtr_pkg::SLOT_W-1:0];
      o_ioff_r <= ioff_r[moe_rtr_pkg::OFF_W-1:0];
      o_ooff_r <= kept_r ? ooff_r[moe_rtr_pkg::OFF_W-1:0] : '0;
      o_last_r <= res_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_expert_id     = o_eid_r;
  assign out_weight        = o_w_r;
  assign out_token_index   = o_tok_r;
  assign out_kept          = o_kept_r;
  assign out_slot          = o_slot_r;
  assign out_input_offset  = o_ioff_r;
  assign out_output_offset = o_ooff_r;
  assign out_last          = o_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/moe_rtr_chk.sv
`default_nettype none
module moe_rtr_chk (
  input wire                                   clk,
  input wire                                   rst_n,
  input wire                                   in_stall,
  input wire                                   out_valid,
  input wire                                   out_stall,
  input wire [moe_rtr_pkg::EID_W-1:0]          out_expert_id,
  input wire [moe_rtr_pkg::W_W-1:0]            out_weight,
  input wire [moe_rtr_pkg::TOK_W-1:0]          out_token_index,
  input wire                                   out_kept,
  input wire [moe_rtr_pkg::SLOT_W-1:0]         out_slot,
  input wire [moe_rtr_pkg::OFF_W-1:0]          out_input_offset,
  input wire [moe_rtr_pkg::OFF_W-1:0]          out_output_offset,
  input wire                                   out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_expert_id) && $stable(out_weight)
      && $stable(out_slot) && $stable(out_last) && $stable(out_token_index)
      && $stable(out_kept) && $stable(out_input_offset)
      && $stable(out_output_offset))
    else $error("stalled out beat changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kept |-> out_slot == '0 && out_output_offset == '0)
    else $error("dropped beat carries a slot");

  // a non-last beat waiting means the token's results are still being built
  a_busy_mid_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken before token results finished");

endmodule

bind moe_topk_router_with_capacity moe_rtr_chk u_moe_rtr_chk (.*);
`default_nettype wire

FILE: tb/moe_topk_router_with_capacity_tb.sv
`timescale 1ns / 1ps
module moe_topk_router_with_capacity_tb;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [moe_rtr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [moe_rtr_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [moe_rtr_pkg::SCORE_W-1:0] in_score;
  logic in_batch_start;
  logic out_valid;
  logic out_stall;
  logic [moe_rtr_pkg::EID_W-1:0] out_expert_id;
  logic [moe_rtr_pkg::W_W-1:0] out_weight;
  logic [moe_rtr_pkg::TOK_W-1:0] out_token_index;
  logic out_kept;
  logic [moe_rtr_pkg::SLOT_W-1:0] out_slot;
  logic [moe_rtr_pkg::OFF_W-1:0] out_input_offset;
  logic [moe_rtr_pkg::OFF_W-1:0] out_output_offset;
  logic out_last;

  moe_topk_router_with_capacity uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_score(in_score),
    .in_batch_start(in_batch_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_expert_id(out_expert_id),
    .out_weight(out_weight), .out_token_index(out_token_index), .out_kept(out_kept),
    .out_slot(out_slot), .out_input_offset(out_input_offset),
    .out_output_offset(out_output_offset), .out_last(out_last)
  );

  typedef struct {
    logic [moe_rtr_pkg::EID_W-1:0] eid;
    logic [moe_rtr_pkg::W_W-1:0] w;
    logic [moe_rtr_pkg::TOK_W-1:0] tok;
    logic kept;
    logic [moe_rtr_pkg::SLOT_W-1:0] slot;
    logic [moe_rtr_pkg::OFF_W-1:0] ioff;
    logic [moe_rtr_pkg::OFF_W-1:0] ooff;
    logic last;
  } gate_t;

  typedef struct {
    logic signed [moe_rtr_pkg::SCORE_W-1:0] sc;
    bit bs;
    bit gold;
    int gid;
    int gw;
  } drow_t;

  typedef struct {
    int ne, k, cap, hd, jen, eps, toks;
    bit idle;
    bit press;
  } phase_t;

  gate_t gate_q[$];
  int fails = 0;
  int quiet_cyc = 0;
  bit idle_on = 1;
  bit hold_req = 0;
  int run_left = 0;

  // router shadow state
  logic [16:0] exp_tab[256];
  int ne_r, k_r, cap_r, hd_r, jen_r, eps_r;
  int top_sc[8];
  int top_id[8];
  int fill_n, tok_n, sc_n;
  int exp_cnt[64];
  logic [31:0] seed;

  drow_t drows[26];
  phase_t phases[7];

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic route_score(input logic signed [15:0] raw, input logic bs,
                             output int nres);
    int n, k, f, p, r, j, d, idx, id;
    longint s, num, mag, q, sum, w;
    longint e[8];
    gate_t g;
    nres = 0;
    n = (ne_r < 1) ? 1 : (ne_r > 64 ? 64 : ne_r);
    k = (k_r < 1) ? 1 : (k_r > 8 ? 8 : k_r);
    if (k > n) k = n;
    if (bs) begin
      for (int i = 0; i < 64; i++) exp_cnt[i] = 0;
      tok_n = 0;
      sc_n = 0;
    end
    if (sc_n == 0) fill_n = 0;
    s = raw;
    if (jen_r != 0 && eps_r > 0) begin
      seed = seed * 32'd1664525 + 32'd1013904223;
      num = (2 * longint'(seed[15:0]) - 65535) * longint'(eps_r);
      mag = num < 0 ? -num : num;
      q = (mag + 32767) / 65535;
      s = s + (num < 0 ? -q : q);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end
    f = fill_n < k ? fill_n : k;
    p = f;
    for (int i = 0; i < f; i++) begin
      if (s > top_sc[i]) begin
        p = i;
        break;
      end
    end
    if (p < k) begin
      for (j = (f < k - 1) ? f : k - 1; j > p; j--) begin
        top_sc[j] = top_sc[j-1];
        top_id[j] = top_id[j-1];
      end
      top_sc[p] = int'(s);
      top_id[p] = sc_n;
    end
    if (fill_n < 8) fill_n++;
    if (sc_n + 1 < n) begin
      sc_n++;
      return;
    end
    r = fill_n < k ? fill_n : k;
    sum = 0;
    for (int i = 0; i < r; i++) begin
      d = top_sc[0] - top_sc[i];
      if (d < 0) d = 0;
      idx = d >> 4;
      e[i] = (idx >= 256) ? 0 : longint'(exp_tab[idx]);
      sum += e[i];
    end
    for (int i = 0; i < r; i++) begin
      id = top_id[i] % 64;
      w = (e[i] * 65536 + sum / 2) / sum;
      if (w > 65535) w = 65535;
      g.eid = id[5:0];
      g.w = w[15:0];
      g.tok = tok_n[11:0];
      g.kept = exp_cnt[id] < cap_r;
      g.slot = g.kept ? exp_cnt[id][11:0] : '0;
      g.ioff = moe_rtr_pkg::OFF_W'(longint'(tok_n) * hd_r);
      g.ooff = g.kept ? moe_rtr_pkg::OFF_W'(longint'(exp_cnt[id]) * hd_r) : '0;
      g.last = (i + 1 == r);
      if (g.kept && exp_cnt[id] < moe_rtr_pkg::CNT_SAT) exp_cnt[id]++;
      gate_q = {gate_q, g};
    end
    tok_n = (tok_n + 1) % 4096;
    sc_n = 0;
    fill_n = 0;
    nres = r;
  endtask

  task automatic wr_reg(input logic [moe_rtr_pkg::CFG_IDX_W-1:0] idx, input int v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = v[15:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      moe_rtr_pkg::REG_NUM_EXPERTS: ne_r = v & 'h7F;
      moe_rtr_pkg::REG_TOP_K:       k_r = v & 'hF;
      moe_rtr_pkg::REG_CAPACITY:    cap_r = v & 'h1FFF;
      moe_rtr_pkg::REG_HIDDEN_DIM:  hd_r = v & 'hFFFF;
      moe_rtr_pkg::REG_JITTER_EN:   jen_r = v & 1;
      moe_rtr_pkg::REG_JITTER_EPS:  eps_r = v & 'h7FFF;
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_beat(input logic signed [15:0] sc, input logic bs, output int nres);
    int g;
    g = (idle_on && $urandom_range(0, 1)) ? pick_gap() : 0;
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1;
    in_score = sc;
    in_batch_start = bs;
    do @(posedge clk); while (in_stall);
    route_score(sc, bs, nres);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_score();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'sd256;
    if (r == 3) return 16'sd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic chk_field(input string nm, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    gate_t g;
    if (out_valid && !out_stall) begin
      if (gate_q.size() == 0) begin
        $error("result beat with nothing pending: expert %0d", out_expert_id);
        fails++;
      end else begin
        g = gate_q.pop_front();
        chk_field("expert_id", g.eid, out_expert_id);
        chk_field("weight", g.w, out_weight);
        chk_field("token_index", g.tok, out_token_index);
        chk_field("kept", g.kept, out_kept);
        chk_field("slot", g.slot, out_slot);
        chk_field("input_offset", g.ioff, out_input_offset);
        chk_field("output_offset", g.ooff, out_output_offset);
        chk_field("last", g.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= 5000) begin
      $display("moe_topk_router_with_capacity regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (500) @(negedge clk);
        hold_req = 0;
        out_stall = 0;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        out_stall = idle_on && ($urandom_range(0, 2) == 0);
        run_left = out_stall ? pick_gap() : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    logic [63:0] v;
    int nres, n_eff, base;
    logic bs;
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_score = '0;
    in_batch_start = 0;

    v = 64'h1_0000_0000;
    for (int i = 0; i < 256; i++) begin
      exp_tab[i] = 17'((v + 64'h8000) >> 16);
      v = (v * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    ne_r = 8; k_r = 2; cap_r = 4096; hd_r = 1; jen_r = 0; eps_r = 0;
    fill_n = 0; tok_n = 0; sc_n = 0; seed = 32'd42;
    for (int i = 0; i < 64; i++) exp_cnt[i] = 0;
    for (int i = 0; i < 8; i++) begin
      top_sc[i] = 0;
      top_id[i] = 0;
    end

    // all-equal token: tie goes to lowest index, even split
    for (int i = 0; i < 8; i++) drows[i] = '{16'sd0, i == 0, i == 7, 0, 32768};
    // one far-ahead expert takes the whole weight
    for (int i = 8; i < 16; i++)
      drows[i] = '{(i == 13) ? 16'sh7FFF : 16'sh8000, 0, i == 15, 5, 65535};
    // partial token then batch restart
    drows[16] = '{16'sd100, 0, 0, 0, 0};
    drows[17] = '{-16'sd5, 0, 0, 0, 0};
    for (int i = 18; i < 26; i++)
      drows[i] = '{16'(300 - 97 * i), i == 18, 0, 0, 0};

    phases[0] = '{4, 3, 2, 100, 0, 0, 10, 1, 0};
    phases[1] = '{64, 8, 4096, 65535, 0, 0, 1, 1, 0};
    phases[2] = '{5, 8, 1, 3, 1, 32767, 8, 1, 0};
    phases[3] = '{0, 0, 0, 1, 1, 0, 20, 0, 0};
    phases[4] = '{100, 15, 4096, 2, 0, 1, 1, 1, 0};
    phases[5] = '{3, 2, 4096, 7, 1, 300, 10, 1, 1};
    phases[6] = '{1, 1, 4096, 65535, 0, 0, 4, 0, 0};

    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    foreach (drows[i]) begin
      send_beat(drows[i].sc, drows[i].bs, nres);
      if (drows[i].gold) begin
        base = gate_q.size() - nres;
        gate_q[base].eid = drows[i].gid[5:0];
        gate_q[base].w = drows[i].gw[15:0];
      end
    end

    foreach (phases[pi]) begin
      in_valid = 0;
      wait (gate_q.size() == 0);
      repeat (60) @(negedge clk);
      wr_reg(moe_rtr_pkg::REG_NUM_EXPERTS, phases[pi].ne);
      wr_reg(moe_rtr_pkg::REG_TOP_K, phases[pi].k);
      wr_reg(moe_rtr_pkg::REG_CAPACITY, phases[pi].cap);
      wr_reg(moe_rtr_pkg::REG_HIDDEN_DIM, phases[pi].hd);
      wr_reg(moe_rtr_pkg::REG_JITTER_EN, phases[pi].jen);
      wr_reg(moe_rtr_pkg::REG_JITTER_EPS, phases[pi].eps);
      idle_on = phases[pi].idle;
      if (phases[pi].press) hold_req = 1;
      n_eff = (ne_r < 1) ? 1 : (ne_r > 64 ? 64 : ne_r);
      for (int t = 0; t < phases[pi].toks; t++) begin
        for (int x = 0; x < n_eff; x++) begin
          // fresh batch at phase start and now and then; rarely a mid-token restart
          if (phases[pi].toks > 1000)
            bs = (t == 0 && x == 0);
          else if (x == 0)
            bs = (t == 0) || ($urandom_range(0, 5) == 0);
          else
            bs = ($urandom_range(0, 49) == 0);
          send_beat(rand_score(), bs, nres);
        end
      end
    end

    in_valid = 0;
    idle_on = 1;
    wait (gate_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && gate_q.size() == 0)
      $display("moe_topk_router_with_capacity regression: pass");
    else
      $display("moe_topk_router_with_capacity regression: fail");
    $finish;
  end

endmodule

FILE: moe_topk_router_with_capacity.f
rtl/core/moe_rtr_pkg.sv
rtl/core/moe_rtr_cell.sv
rtl/core/moe_rtr_div.sv
rtl/core/moe_topk_router_with_capacity.sv
rtl/core/moe_rtr_chk.sv
tb/moe_topk_router_with_capacity_tb.sv
